// File: src/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and character helpers for the streaming base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [15:0] MAX_BYTES_RST = 16'hFFFF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CHR = 2'd1;
    localparam logic [1:0] ST_AFT_PAD = 2'd2;
    localparam logic [1:0] ST_OVERRUN = 2'd3;

    localparam logic KIND_CHR = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [7:0] PAD_CHR = 8'h3D;

    typedef struct packed {
        logic       kind;
        logic [7:0] chr;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } t_out_item;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        case (c) inside
            [8'h41:8'h5A]: s.value = 6'(c - 8'd65);
            [8'h61:8'h7A]: s.value = 6'(c - 8'd71);
            [8'h30:8'h39]: s.value = 6'(c + 8'd4);
            8'h2B:         s.value = 6'd62;
            8'h2F:         s.value = 6'd63;
            default:       s.ok    = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

endpackage

// File: src/base64_decoder.sv
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming base64 decoder: one character per item in, one byte or status out.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_item  (kind, chr)
//  output   | o_out_valid  | i_out_stall  | o_out_item (kind, byte, status, count)
//  config   | i_cfg_we     | -            | i_cfg_data (max_output_bytes)
//
//  One item per cycle sustained unless the output stalls; a result-producing
//  item passes the input register, then is decoded into the result register.
//  Decode state updates as the item leaves the input register.
//  Output stall holds the result register and backs up into the input register.
//  Synchronous active-low reset clears control and per-string state.
module base64_decoder
#(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  b64d_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output b64d_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data
);
    import b64d_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic                   r_in_valid;
    t_in_item               r_in;
    logic [15:0]            r_max_bytes;
    logic [1:0]             r_pos,    n_pos;
    logic [5:0]             r_held,   n_held;
    logic                   r_pad,    n_pad;
    logic [1:0]             r_err,    n_err;
    logic [COUNT_WIDTH-1:0] r_bytes,  n_bytes;
    logic                   r_out_valid;
    t_out_item              r_out,    n_out;
    logic                   n_emit;
    logic                   advance;
    t_sextet                sx;
    logic [7:0]             dec_byte;
    logic [CMP_W-1:0]       bytes_ext;
    logic                   full;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign sx        = sextet_of(r_in.chr);
    assign bytes_ext = CMP_W'(r_bytes);
    assign full      = (bytes_ext >= CMP_W'(r_max_bytes)) || (&r_bytes);

    always_comb begin
        n_pos    = r_pos;
        n_held   = r_held;
        n_pad    = r_pad;
        n_err    = r_err;
        n_bytes  = r_bytes;
        n_emit   = 1'b0;
        n_out    = '0;
        dec_byte = '0;
        case (r_pos)
            2'd1:    dec_byte = {r_held[5:0], sx.value[5:4]};
            2'd2:    dec_byte = {r_held[3:0], sx.value[5:2]};
            default: dec_byte = {r_held[1:0], sx.value};
        endcase
        if (r_in.kind == KIND_END) begin
            n_emit               = 1'b1;
            n_out.result_kind    = KIND_END;
            n_out.status         = r_err;
            n_out.byte_count     = bytes_ext[15:0];
            n_pos                = '0;
            n_held               = '0;
            n_pad                = 1'b0;
            n_err                = ST_OK;
            n_bytes              = '0;
        end else if (r_err != ST_OK || is_blank(r_in.chr)) begin
            // skipped
        end else if (r_in.chr == PAD_CHR) begin
            n_pad  = 1'b1;
            n_pos  = '0;
            n_held = '0;
        end else if (r_pad) begin
            n_err = ST_AFT_PAD;
        end else if (!sx.ok) begin
            n_err = ST_BAD_CHR;
        end else begin
            case (r_pos)
                2'd0:    n_held = sx.value;
                2'd1:    n_held = {2'b00, sx.value[3:0]};
                2'd2:    n_held = {4'b0000, sx.value[1:0]};
                default: n_held = '0;
            endcase
            n_pos = r_pos + 2'd1;
            if (r_pos != 2'd0) begin
                if (full) begin
                    n_err = ST_OVERRUN;
                end else begin
                    n_bytes           = r_bytes + 1'b1;
                    n_emit            = 1'b1;
                    n_out.result_kind = KIND_CHR;
                    n_out.data_byte   = dec_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_bytes <= MAX_BYTES_RST;
            r_pos       <= '0;
            r_held      <= '0;
            r_pad       <= 1'b0;
            r_err       <= ST_OK;
            r_bytes     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_bytes <= i_cfg_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid && n_emit;
            end
            if (r_in_valid && advance) begin
                r_pos   <= n_pos;
                r_held  <= n_held;
                r_pad   <= n_pad;
                r_err   <= n_err;
                r_bytes <= n_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance && r_in_valid && n_emit) begin
            r_out <= n_out;
        end
    end

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.result_kind == KIND_CHR)
            |-> (r_out.status == ST_OK && r_out.byte_count == 16'd0))
        else $error("data item carries status or count");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in.kind == KIND_CHR && r_err != ST_OK)
            |=> !r_out_valid)
        else $error("data emitted while error is set");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in.kind == KIND_END)
            |=> (r_err == ST_OK && r_bytes == '0 && r_pos == 2'd0 && !r_pad))
        else $error("end item did not clear string state");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule

// File: tb/sv/base64_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_decoder_tb
// Drives character and end items into the decoder under random valid and
// stall gaps, predicts every data byte and end status in a scoreboard, and
// checks each result field by field. Covers capacities 0, 1, 2, 5, 65535, one in 2-40.
// ----------------------------------------------------------------------------
module base64_decoder_tb;
    import b64d_pkg::*;

    class decode_scoreboard;
        logic [15:0] capacity;
        logic [1:0]  group_pos;
        logic [5:0]  held;
        bit          pad_seen;
        logic [1:0]  err;
        logic [15:0] nbytes;
        t_out_item   decoded_due[$];
        int          mismatches;
        int          n_data;
        int          n_status[4];

        function new();
            capacity = MAX_BYTES_RST;
            clear_string();
        endfunction

        function void clear_string();
            group_pos = 2'd0;
            held      = 6'd0;
            pad_seen  = 1'b0;
            err       = ST_OK;
            nbytes    = 16'd0;
        endfunction

        static function bit sextet_value(input logic [7:0] c, output logic [5:0] v);
            v = 6'd0;
            if (c >= "A" && c <= "Z") v = 6'(c - "A");
            else if (c >= "a" && c <= "z") v = 6'(c - "a" + 26);
            else if (c >= "0" && c <= "9") v = 6'(c - "0" + 52);
            else if (c == "+") v = 6'd62;
            else if (c == "/") v = 6'd63;
            else return 1'b0;
            return 1'b1;
        endfunction

        static function bit blank(input logic [7:0] c);
            return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
        endfunction

        function void predict_decode(input t_in_item it);
            t_out_item  r;
            logic [5:0] s;
            logic [7:0] b;
            r = '0;
            if (it.kind == KIND_END) begin
                r.result_kind = KIND_END;
                r.status      = err;
                r.byte_count  = nbytes;
                decoded_due.push_back(r);
                clear_string();
                return;
            end
            if (err != ST_OK || blank(it.chr)) return;
            if (it.chr == PAD_CHR) begin
                pad_seen  = 1'b1;
                group_pos = 2'd0;
                held      = 6'd0;
                return;
            end
            if (pad_seen) begin
                err = ST_AFT_PAD;
                return;
            end
            if (!sextet_value(it.chr, s)) begin
                err = ST_BAD_CHR;
                return;
            end
            case (group_pos)
                2'd0: begin
                    held      = s;
                    group_pos = 2'd1;
                    return;
                end
                2'd1: begin
                    b         = {held, s[5:4]};
                    held      = {2'b00, s[3:0]};
                    group_pos = 2'd2;
                end
                2'd2: begin
                    b         = {held[3:0], s[5:2]};
                    held      = {4'b0000, s[1:0]};
                    group_pos = 2'd3;
                end
                default: begin
                    b         = {held[1:0], s};
                    held      = 6'd0;
                    group_pos = 2'd0;
                end
            endcase
            if (nbytes >= capacity) begin
                err = ST_OVERRUN;
                return;
            end
            nbytes++;
            r.result_kind = KIND_CHR;
            r.data_byte   = b;
            decoded_due.push_back(r);
        endfunction

        function void check_result(input t_out_item got);
            t_out_item want;
            if (decoded_due.size() == 0) begin
                $error("unexpected result: kind %0d byte %h status %0d count %0d",
                       got.result_kind, got.data_byte, got.status, got.byte_count);
                mismatches++;
                return;
            end
            want = decoded_due.pop_front();
            if (got.result_kind !== want.result_kind) begin
                $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
                mismatches++;
            end
            if (got.data_byte !== want.data_byte) begin
                $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.byte_count !== want.byte_count) begin
                $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
                mismatches++;
            end
            if (want.result_kind == KIND_END) n_status[want.status]++;
            else n_data++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    decode_scoreboard sb;
    bit               steady;
    int               items_sent;

    base64_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_item(input logic k, input logic [7:0] c);
        t_in_item it;
        it.kind = k;
        it.chr  = c;
        if (!steady && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.predict_decode(it);
        items_sent++;
    endtask

    task automatic send_end();
        send_item(KIND_END, 8'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(KIND_CHR, s[i]);
    endtask

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    task automatic send_b64();
        logic [7:0] blanks[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
        if ($urandom_range(99) < 10) send_item(KIND_CHR, blanks[$urandom_range(3)]);
        send_item(KIND_CHR, alpha_char(6'($urandom)));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.decoded_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.capacity = v;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_random_string();
        int         mode;
        int         tail;
        int         npad;
        logic [7:0] c;
        logic [5:0] v;
        mode = $urandom_range(99);
        if (mode < 12) begin
            repeat ($urandom_range(1, 8)) send_item(KIND_CHR, 8'($urandom));
        end else begin
            repeat ($urandom_range(0, 5) * 4) send_b64();
            tail = $urandom_range(0, 3);
            repeat (tail) send_b64();
            if (mode < 60) npad = (tail == 0) ? 0 : 4 - tail;
            else if (mode < 75) npad = $urandom_range(0, 3);
            else npad = 0;
            repeat (npad) send_item(KIND_CHR, PAD_CHR);
            if (mode >= 75 && mode < 88) begin
                do c = 8'($urandom);
                while (decode_scoreboard::sextet_value(c, v) ||
                       decode_scoreboard::blank(c) || c == PAD_CHR);
                send_item(KIND_CHR, c);
                repeat ($urandom_range(0, 4)) send_b64();
            end else if (mode >= 88) begin
                send_item(KIND_CHR, PAD_CHR);
                send_item(KIND_CHR, 8'($urandom));
                repeat ($urandom_range(0, 3)) send_b64();
            end
        end
        send_end();
    endtask

    // receiver: check accepted results, stall at random
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_item);
            i_out_stall <= !steady && ($urandom_range(99) < 13);
        end
    end

    initial begin
        #20ms;
        $display("base64_decoder test failed");
        $finish;
    end

    initial begin
        logic [15:0] caps[6];
        int          start;
        sb         = new();
        steady     = 1'b0;
        items_sent = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: alphabet extremes, blanks, padding, sticky errors, empty string
        send_text("TWFu /\t/\n/\r/");
        send_end();
        send_text("az09+Z==");
        send_end();
        send_text("Q=x");
        send_end();
        send_text("*=x");
        send_end();
        send_item(KIND_CHR, 8'hFF);
        send_end();
        send_item(KIND_END, 8'h00);

        // capacity edges
        wait_idle();
        write_capacity(16'd0);
        send_text("AAAA");
        send_end();
        wait_idle();
        write_capacity(16'd1);
        send_text("AAAA");
        send_end();
        wait_idle();
        write_capacity(16'd2);
        send_text("AAA");
        send_end();

        caps = '{16'hFFFF, 16'd0, 16'd1, 16'd5, 16'($urandom_range(2, 40)), 16'hFFFF};
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_capacity(caps[p]);
            steady = (p == 3);
            start  = items_sent;
            while (items_sent - start < 120) begin
                send_random_string();
                if ($urandom_range(99) < 4) wait_idle();
            end
        end
        steady = 1'b0;

        wait_idle();
        $display("%0d items sent; %0d data bytes and %0d end statuses checked",
                 items_sent, sb.n_data,
                 sb.n_status[0] + sb.n_status[1] + sb.n_status[2] + sb.n_status[3]);
        $display("statuses ok/invalid/after-pad/capacity: %0d/%0d/%0d/%0d",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
        if (sb.mismatches == 0 && sb.decoded_due.size() == 0) begin
            $display("base64_decoder test passed");
        end else begin
            $display("base64_decoder test failed");
        end
        $finish;
    end
endmodule
